FILE: rtl/atop_pkg.sv
// atop_pkg: shared types, fixed-point formats and coefficients of the atan2 unit.
// No dependencies; used by atop_out_if and the top level.
package atop_pkg;

    // Fixed-point formats: t is Q28 unsigned, the accumulator is Q24 degrees
    localparam int T_FRAC    = 28;
    localparam int ACC_FRAC  = 24;
    localparam int T_W       = T_FRAC + 1;
    localparam int ACC_W     = 32;
    localparam int PROD_W    = 62;
    localparam int ANG_W     = 36;
    localparam int OUT_W     = 16;
    localparam int DIV_STEPS = T_W;

    // Polynomial coefficients in Q24 degrees; c1 makes t = 1 land on 45 exactly
    localparam longint DEG45_Q24 = 64'sd754974720;
    localparam logic signed [ACC_W-1:0] COEF3 = -32'sd63731781;
    localparam logic signed [ACC_W-1:0] COEF2 = -32'sd171489438;
    localparam logic signed [ACC_W-1:0] COEF1 = 32'sd990195939;

    localparam logic signed [ANG_W-1:0] DEG90_Q24  = ANG_W'(2 * DEG45_Q24);
    localparam logic signed [ANG_W-1:0] DEG180_Q24 = ANG_W'(4 * DEG45_Q24);
    localparam logic signed [ANG_W-1:0] DEG360_Q24 = ANG_W'(8 * DEG45_Q24);

    localparam logic signed [PROD_W-1:0] RND_T = PROD_W'(longint'(1) << (T_FRAC - 1));

    // Special results for a zero abscissa
    typedef enum logic [1:0] {
        SPEC_NONE,
        SPEC_ZERO,
        SPEC_POS90,
        SPEC_NEG90
    } t_spec;

    // Side information that travels with each beat
    typedef struct packed {
        logic [2:0] oct;
        t_spec      spec;
    } t_side;

    // Q24 x Q28 product back to Q24, half away from zero
    function automatic logic signed [ACC_W-1:0] mul_round(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] sum;
        sum = p + (p[PROD_W-1] ? (RND_T - PROD_W'(1)) : RND_T);
        return sum[ACC_W+T_FRAC-1:T_FRAC];
    endfunction

    // Octant count times 45 degrees
    function automatic logic signed [ANG_W-1:0] oct_angle(input logic [2:0] oct);
        return ANG_W'(longint'({61'd0, oct}) * DEG45_Q24);
    endfunction

endpackage

FILE: rtl/atop_in_if.sv
// atop_in_if: request channel of the atan2 unit, a coordinate pair per beat.
// Depends on nothing but its width parameter.
interface atop_in_if #(
    parameter int IN_WIDTH = 16
);
    logic                       valid;
    logic                       ready;
    logic signed [IN_WIDTH-1:0] y_val;
    logic signed [IN_WIDTH-1:0] x_val;

    modport source (output valid, output y_val, output x_val, input ready);
    modport sink   (input valid, input y_val, input x_val, output ready);
endinterface

FILE: rtl/atop_out_if.sv
// atop_out_if: result channel of the atan2 unit, one angle per beat.
// Depends on atop_pkg for the output width.
interface atop_out_if
    import atop_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] angle_deg;

    modport source (output valid, output angle_deg, input ready);
    modport sink   (input valid, input angle_deg, output ready);
endinterface

FILE: rtl/atan2_octant_polynomial_unit.sv
// atan2_octant_polynomial_unit: pipelined four-quadrant arctangent in degrees.
// Depends on atop_pkg, atop_in_if and atop_out_if.
//
// Usage:
//   i_req carries one (y_val, x_val) pair per beat, signed IN_WIDTH bits each.
//   o_rsp carries one angle_deg per beat, signed 16 bits with OUT_FRAC_BITS
//   fraction bits, range -180..+180 degrees.
//   The path from i_req to o_rsp.valid runs through 39 register stages, the
//   first loaded at the accepting edge: one stage of octant
//   reduction, one that forms the dividend, 29 restoring-divider stages
//   (one quotient bit each), three multiply and three round/add stages of the
//   cubic, one stage that adds the octant offset and wraps, and the output
//   rounding register.
//   One beat per cycle unless o_rsp stalls; every stage holds one beat.
//   A stage loads whenever it is empty or the stage after it moves, so bubbles
//   close up and i_req.ready stays high while any stage has room, even when
//   o_rsp is stalled. A stall on o_rsp holds the output register and fills the
//   pipeline from the back; nothing is dropped or repeated.
//   Synchronous active-low reset empties all stages; no clearing pass.
module atan2_octant_polynomial_unit
    import atop_pkg::*;
#(
    parameter int IN_WIDTH      = 16,
    parameter int OUT_FRAC_BITS = 7
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    atop_in_if.sink         i_req,
    atop_out_if.source      o_rsp
);

    localparam int UW  = IN_WIDTH + 1;
    localparam int WW  = IN_WIDTH + 2;
    localparam int NW  = IN_WIDTH + T_FRAC + 1;
    localparam int SH  = ACC_FRAC - OUT_FRAC_BITS;
    localparam logic signed [ANG_W-1:0] RND_O = ANG_W'(longint'(1) << (SH - 1));

    // Stage indexes
    localparam int S_A   = 0;
    localparam int S_B   = 1;
    localparam int S_D0  = 2;
    localparam int S_M1  = S_D0 + DIV_STEPS;
    localparam int S_R1  = S_M1 + 1;
    localparam int S_M2  = S_R1 + 1;
    localparam int S_R2  = S_M2 + 1;
    localparam int S_M3  = S_R2 + 1;
    localparam int S_R3  = S_M3 + 1;
    localparam int S_F   = S_R3 + 1;
    localparam int S_G   = S_F + 1;
    localparam int NST   = S_G + 1;

    // Pipeline control
    logic [NST-1:0] r_v;
    logic [NST:0]   w_adv;
    t_side          r_side [0:S_R3];

    // Stage A: reduction
    logic signed [WW-1:0] a_y0, a_x0, a_y1, a_x1, a_y2, a_x2, a_y3, a_x3;
    logic [2:0]           a_oct;
    t_side                n_side_a;
    logic [UW-1:0]        r_ya, r_xa;

    // Stage B and divider
    logic [NW-1:0]        n_num;
    logic [UW-1:0]        r_rem [0:DIV_STEPS];
    logic [UW-1:0]        r_den [0:DIV_STEPS];
    logic [T_W-1:0]       r_nlo [0:DIV_STEPS];
    logic [T_W-1:0]       r_quo [0:DIV_STEPS];

    // Polynomial
    logic signed [PROD_W-1:0] r_p1, r_p2, r_p3;
    logic signed [ACC_W-1:0]  r_a2, r_a1, r_a0;
    logic [T_W-1:0]           r_tm1, r_tr1, r_tm2, r_tr2;

    // Angle and output
    logic signed [ANG_W-1:0]  n_ang, n_sum;
    logic signed [ANG_W-1:0]  r_ang;
    logic signed [OUT_W-1:0]  r_angle;

    // Advance chain: a stage loads when empty or when its successor loads
    always_comb begin
        w_adv[NST] = o_rsp.ready;
        for (int s = NST - 1; s >= 0; s--) begin
            w_adv[s] = !r_v[s] || w_adv[s+1];
        end
    end

    assign i_req.ready     = w_adv[0];
    assign o_rsp.valid     = r_v[NST-1];
    assign o_rsp.angle_deg = r_angle;

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int s = 0; s < NST; s++) begin
                if (w_adv[s]) begin
                    r_v[s] <= (s == 0) ? i_req.valid : r_v[(s == 0) ? 0 : s - 1];
                end
            end
        end
    end

    // Carry octant and special-case code down to the angle stage
    for (genvar s = 0; s <= S_R3; s++) begin : g_side
        if (s == 0) begin : g_first
            always_ff @(posedge i_clk) begin
                if (w_adv[s]) begin
                    r_side[s] <= n_side_a;
                end
            end
        end else begin : g_next
            always_ff @(posedge i_clk) begin
                if (w_adv[s]) begin
                    r_side[s] <= r_side[s-1];
                end
            end
        end
    end

    // Stage A: flip, rotate and fold into the first octant
    always_comb begin
        a_y0  = WW'(i_req.y_val);
        a_x0  = WW'(i_req.x_val);
        a_oct = 3'd0;
        a_y1  = a_y0;
        a_x1  = a_x0;
        if (a_y0 < 0) begin
            a_y1  = -a_y0;
            a_x1  = -a_x0;
            a_oct = 3'd4;
        end
        a_y2 = a_y1;
        a_x2 = a_x1;
        if (a_x1 <= 0) begin
            a_x2  = a_y1;
            a_y2  = -a_x1;
            a_oct = a_oct + 3'd2;
        end
        a_y3 = a_y2;
        a_x3 = a_x2;
        if (a_x2 <= a_y2) begin
            a_y3  = a_y2 - a_x2;
            a_x3  = a_x2 + a_y2;
            a_oct = a_oct + 3'd1;
        end
        n_side_a.oct = a_oct;
        if (i_req.x_val != '0) begin
            n_side_a.spec = SPEC_NONE;
        end else if (i_req.y_val == '0) begin
            n_side_a.spec = SPEC_ZERO;
        end else if (i_req.y_val[IN_WIDTH-1]) begin
            n_side_a.spec = SPEC_NEG90;
        end else begin
            n_side_a.spec = SPEC_POS90;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[S_A]) begin
            r_ya <= a_y3[UW-1:0];
            r_xa <= a_x3[UW-1:0];
        end
    end

    // Stage B: dividend y * 2^28 + x/2, split into the first partial remainder
    assign n_num = {r_ya, {T_FRAC{1'b0}}} + NW'(r_xa >> 1);

    always_ff @(posedge i_clk) begin
        if (w_adv[S_B]) begin
            r_rem[0] <= {1'b0, n_num[NW-1:T_W]};
            r_nlo[0] <= n_num[T_W-1:0];
            r_den[0] <= r_xa;
            r_quo[0] <= '0;
        end
    end

    // Divider: one restoring step per stage, most significant quotient bit first
    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
        localparam int BI = DIV_STEPS - 1 - k;
        logic [UW:0]    w_trial;
        logic [UW:0]    w_diff;
        logic           w_ge;
        logic [T_W-1:0] n_quo;

        always_comb begin
            w_trial   = {r_rem[k], r_nlo[k][BI]};
            w_diff    = w_trial - {1'b0, r_den[k]};
            w_ge      = w_trial >= {1'b0, r_den[k]};
            n_quo     = r_quo[k];
            n_quo[BI] = w_ge;
        end

        always_ff @(posedge i_clk) begin
            if (w_adv[S_D0+k]) begin
                r_rem[k+1] <= w_ge ? w_diff[UW-1:0] : w_trial[UW-1:0];
                r_nlo[k+1] <= r_nlo[k];
                r_den[k+1] <= r_den[k];
                r_quo[k+1] <= n_quo;
            end
        end
    end

    // Horner evaluation: multiply, then round and add the next coefficient
    always_ff @(posedge i_clk) begin
        if (w_adv[S_M1]) begin
            r_p1  <= COEF3 * $signed({1'b0, r_quo[DIV_STEPS]});
            r_tm1 <= r_quo[DIV_STEPS];
        end
        if (w_adv[S_R1]) begin
            r_a2  <= COEF2 + mul_round(r_p1);
            r_tr1 <= r_tm1;
        end
        if (w_adv[S_M2]) begin
            r_p2  <= r_a2 * $signed({1'b0, r_tr1});
            r_tm2 <= r_tr1;
        end
        if (w_adv[S_R2]) begin
            r_a1  <= COEF1 + mul_round(r_p2);
            r_tr2 <= r_tm2;
        end
        if (w_adv[S_M3]) begin
            r_p3 <= r_a1 * $signed({1'b0, r_tr2});
        end
        if (w_adv[S_R3]) begin
            r_a0 <= mul_round(r_p3);
        end
    end

    // Add the octant offset, wrap above 180, and substitute the zero-x answers
    always_comb begin
        n_ang = oct_angle(r_side[S_R3].oct) + ANG_W'(r_a0);
        if (n_ang > DEG180_Q24) begin
            n_ang = n_ang - DEG360_Q24;
        end
        case (r_side[S_R3].spec)
            SPEC_NONE:  n_ang = n_ang;
            SPEC_ZERO:  n_ang = '0;
            SPEC_POS90: n_ang = DEG90_Q24;
            SPEC_NEG90: n_ang = -DEG90_Q24;
            default:    n_ang = n_ang;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[S_F]) begin
            r_ang <= n_ang;
        end
    end

    // Round to the output fraction, half away from zero, keep the low 16 bits
    assign n_sum = r_ang + (r_ang[ANG_W-1] ? (RND_O - ANG_W'(1)) : RND_O);

    always_ff @(posedge i_clk) begin
        if (w_adv[S_G]) begin
            r_angle <= n_sum[SH+OUT_W-1:SH];
        end
    end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// testbench: self-checking bench for atan2_octant_polynomial_unit (y, x -> degrees in Q7).
// Depends on atop_in_if, atop_out_if and the unit itself; holds its own angle predictor.

// Predictor formats: ratio in Q28, polynomial in Q24 degrees
localparam int     RATIO_FRAC   = 28;
localparam int     POLY_FRAC    = 24;
localparam int     ANGLE_FRAC   = 7;
localparam longint QUARTER_OCT  = 754974720;     // 45 degrees in Q24
localparam longint CUBE_COEF    = -63731781;
localparam longint SQUARE_COEF  = -171489438;
localparam longint LINEAR_COEF  = QUARTER_OCT - SQUARE_COEF - CUBE_COEF;

typedef struct packed {
    logic signed [15:0] y_val;
    logic signed [15:0] x_val;
    logic signed [15:0] angle;
} t_angle_job;

class angle_scoreboard;
    t_angle_job  pending_angles[$];
    int unsigned requests_noted;
    int unsigned angles_checked;
    int unsigned mismatches;

    // Round a * 2^-sh on the magnitude, half away from zero
    function longint round_half_away(longint a, int sh);
        longint mag;
        mag = (a < 0) ? -a : a;
        mag = (mag + (longint'(1) <<< (sh - 1))) >>> sh;
        return (a < 0) ? -mag : mag;
    endfunction

    function logic signed [15:0] predict_angle(logic signed [15:0] y_in,
                                               logic signed [15:0] x_in);
        longint yy, xx, swap, ratio, acc, ang;
        int     oct;
        yy  = y_in;
        xx  = x_in;
        oct = 0;
        if (xx == 0) begin
            // Zero abscissa acts as a tiny positive value
            if (yy == 0)
                ang = 0;
            else
                ang = (yy > 0) ? 2 * QUARTER_OCT : -2 * QUARTER_OCT;
        end else begin
            // Fold into the first octant: flip, rotate, then 45-degree fold
            if (yy < 0) begin
                xx  = -xx;
                yy  = -yy;
                oct += 4;
            end
            if (xx <= 0) begin
                swap = xx;
                xx   = yy;
                yy   = -swap;
                oct += 2;
            end
            if (xx <= yy) begin
                swap = yy - xx;
                xx   = xx + yy;
                yy   = swap;
                oct += 1;
            end
            ratio = ((yy <<< RATIO_FRAC) + (xx >>> 1)) / xx;
            // Horner evaluation of the cubic
            acc = CUBE_COEF;
            acc = SQUARE_COEF + round_half_away(acc * ratio, RATIO_FRAC);
            acc = LINEAR_COEF + round_half_away(acc * ratio, RATIO_FRAC);
            acc = round_half_away(acc * ratio, RATIO_FRAC);
            ang = oct * QUARTER_OCT + acc;
            if (ang > 4 * QUARTER_OCT)
                ang -= 8 * QUARTER_OCT;
        end
        return 16'(round_half_away(ang, POLY_FRAC - ANGLE_FRAC));
    endfunction

    function void note_request(logic signed [15:0] y_in, logic signed [15:0] x_in);
        t_angle_job job;
        job.y_val = y_in;
        job.x_val = x_in;
        job.angle = predict_angle(y_in, x_in);
        pending_angles.push_back(job);
        requests_noted++;
    endfunction

    function void check_angle(logic signed [15:0] actual);
        t_angle_job job;
        if (pending_angles.size() == 0) begin
            mismatches++;
            $display("%0t: angle %0d arrived with nothing outstanding", $time, actual);
        end else begin
            job = pending_angles.pop_front();
            angles_checked++;
            if (actual !== job.angle) begin
                mismatches++;
                $display("%0t: y=%0d x=%0d expected angle %0d, got %0d",
                         $time, job.y_val, job.x_val, job.angle, actual);
            end
        end
    endfunction

    function int unsigned pending();
        return pending_angles.size();
    endfunction
endclass

module testbench;

    localparam int LATENCY     = 38;
    localparam int DRAIN_LIMIT = 20000;
    localparam int HOLD_CYCLES = 400;

    logic i_clk = 1'b0;
    logic i_rst_n;

    atop_in_if #(.IN_WIDTH(16)) req_if ();
    atop_out_if                 rsp_if ();

    atan2_octant_polynomial_unit #(
        .IN_WIDTH      (16),
        .OUT_FRAC_BITS (ANGLE_FRAC)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    angle_scoreboard sb = new();

    int  send_idle_pct  = 0;
    int  recv_stall_pct = 0;
    bit  hold_off_req   = 1'b0;
    bit  hold_off_done  = 1'b0;

    const logic signed [15:0] extremes [6] = '{-16'sd32768, -16'sd32767, -16'sd1,
                                               16'sd0, 16'sd1, 16'sd32767};

    always #6 i_clk = ~i_clk;

    // Send one coordinate pair, with random idle cycles in front of it
    task automatic send_pair(input logic signed [15:0] y, input logic signed [15:0] x);
        while ($urandom_range(99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.y_val <= y;
        req_if.x_val <= x;
        do @(posedge i_clk); while (!req_if.ready);
        sb.note_request(y, x);
    endtask

    // Draw a pair, weighted toward octant borders and extreme values
    task automatic pick_pair(output logic signed [15:0] y, output logic signed [15:0] x);
        int m;
        int d;
        m = $urandom_range(32768);
        d = $urandom_range(1) ? 1 : -1;
        case ($urandom_range(9))
            0, 1, 2, 3: begin
                y = 16'($urandom);
                x = 16'($urandom);
            end
            4: begin
                y = 16'($urandom_range(16) - 8);
                x = 16'($urandom_range(16) - 8);
            end
            5: begin
                y = $urandom_range(1) ? 16'($urandom) : 16'sd0;
                x = (y == 0) ? 16'($urandom) : 16'sd0;
            end
            6: begin
                y = $urandom_range(1) ? 16'(m) : 16'(-m);
                x = $urandom_range(1) ? 16'(m) : 16'(-m);
            end
            7: begin
                y = $urandom_range(1) ? 16'(m) : 16'(-m);
                x = $urandom_range(1) ? 16'(m + d) : 16'(-m - d);
            end
            8: begin
                y = extremes[$urandom_range(5)];
                x = extremes[$urandom_range(5)];
            end
            default: begin
                y = 16'($urandom);
                x = 16'(-y + d * $urandom_range(2));
            end
        endcase
    endtask

    task automatic run_random_phase(input int count, input int idle_pct, input int stall_pct);
        logic signed [15:0] y;
        logic signed [15:0] x;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count) begin
            pick_pair(y, x);
            send_pair(y, x);
        end
    endtask

    // Result side: check each beat, stall at random, and hold off once on request
    initial begin
        int hold_left;
        hold_left = 0;
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rsp_if.valid && rsp_if.ready)
                sb.check_angle(rsp_if.angle_deg);
            if (hold_left > 0) begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end else if (hold_off_req && !hold_off_done) begin
                hold_off_done = 1'b1;
                hold_left     = HOLD_CYCLES;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Stimulus and end of run
    initial begin
        int waited;
        i_rst_n      <= 1'b0;
        req_if.valid <= 1'b0;
        req_if.y_val <= '0;
        req_if.x_val <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: zero abscissa, axes, octant borders, most negative values
        send_pair(16'sd0, 16'sd0);
        send_pair(16'sd1, 16'sd0);
        send_pair(-16'sd1, 16'sd0);
        send_pair(16'sd32767, 16'sd0);
        send_pair(-16'sd32768, 16'sd0);
        send_pair(16'sd0, 16'sd32767);
        send_pair(16'sd0, -16'sd1);
        send_pair(16'sd0, -16'sd32768);
        send_pair(16'sd1, 16'sd1);
        send_pair(-16'sd1, -16'sd1);
        send_pair(16'sd1, -16'sd1);
        send_pair(-16'sd1, 16'sd1);
        send_pair(16'sd32767, 16'sd32767);
        send_pair(-16'sd32768, -16'sd32768);
        send_pair(-16'sd32768, 16'sd32767);
        send_pair(16'sd32767, -16'sd32768);
        send_pair(-16'sd32768, -16'sd32767);
        send_pair(16'sd100, 16'sd200);
        send_pair(16'sd200, 16'sd100);
        send_pair(-16'sd5, 16'sd3);
        send_pair(16'sd1, 16'sd32767);
        send_pair(16'sd32767, 16'sd1);

        // Random: free flow, sparse input, stalled output, both, then back-pressure
        run_random_phase(365, 0, 0);
        run_random_phase(365, 80, 0);
        run_random_phase(365, 0, 80);
        run_random_phase(365, 36, 36);
        hold_off_req = 1'b1;
        run_random_phase(370, 0, 0);
        req_if.valid <= 1'b0;

        // Drain outstanding angles
        waited = 0;
        while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (sb.pending() != 0) begin
            $display("%0t: %0d angles never arrived", $time, sb.pending());
            $display("FAILURE");
        end else begin
            repeat (LATENCY + 20) @(posedge i_clk);
            $display("Sent %0d coordinate pairs: axes, octant borders, extremes and random",
                     sb.requests_noted);
            $display("mixes under idle, stall and a %0d-cycle hold; %0d angles checked, %0d bad",
                     HOLD_CYCLES, sb.angles_checked, sb.mismatches);
            if (sb.mismatches == 0) begin
                $display("SUCCESS");
            end else begin
                $display("FAILURE");
            end
        end
        $finish;
    end

    // Guard against a hung handshake
    initial begin
        #5000000;
        $display("%0t: run did not finish in time", $time);
        $display("FAILURE");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/atop_pkg.sv
rtl/atop_in_if.sv
rtl/atop_out_if.sv
rtl/atan2_octant_polynomial_unit.sv
tb/testbench.sv
